FILE: rtl/core/sid_pkg.sv
package sid_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic zero_div;
        logic last;
    } t_status;

endpackage

FILE: rtl/core/sid_ctrl.sv
module sid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  sid_pkg::t_status i_status,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output sid_pkg::t_cmd   o_cmd
);

    sid_pkg::t_state r_state;
    sid_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sid_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sid_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.zero_div ? sid_pkg::ST_DONE : sid_pkg::ST_RUN;
                end
            end
            sid_pkg::ST_RUN: begin
                if (i_status.last) begin
                    n_state = sid_pkg::ST_FINISH;
                end
            end
            sid_pkg::ST_FINISH: begin
                n_state = sid_pkg::ST_DONE;
            end
            sid_pkg::ST_DONE: begin
                if (i_out_ready) begin
                    n_state = sid_pkg::ST_IDLE;
                end
            end
            default: n_state = sid_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == sid_pkg::ST_IDLE);
        o_out_valid  = (r_state == sid_pkg::ST_DONE);
        o_cmd.load   = (r_state == sid_pkg::ST_IDLE) && i_in_valid;
        o_cmd.step   = (r_state == sid_pkg::ST_RUN);
        o_cmd.finish = (r_state == sid_pkg::ST_FINISH);
    end

endmodule

FILE: rtl/core/sid_datapath.sv
module sid_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sid_pkg::t_cmd                i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_dividend,
    input  logic signed [DATA_WIDTH-1:0] i_divisor,
    output sid_pkg::t_status             o_status,
    output logic signed [DATA_WIDTH-1:0] o_quotient,
    output logic                         o_divide_by_zero
);

    localparam int CW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;
    logic [DATA_WIDTH-1:0] r_rem;
    logic                  r_neg;
    logic                  r_dbz;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_quotient;

    logic [DATA_WIDTH-1:0] w_num_mag;
    logic [DATA_WIDTH-1:0] w_den_mag;
    logic [DATA_WIDTH-1:0] w_shift;
    logic                  w_ge;
    logic [DATA_WIDTH-1:0] w_diff;

    // magnitude of the most negative value is exact as unsigned
    assign w_num_mag = i_dividend[DATA_WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_den_mag = i_divisor[DATA_WIDTH-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    // remainder stays below the divisor, so its top bit is always clear
    assign w_shift = {r_rem[DATA_WIDTH-2:0], r_num[DATA_WIDTH-1]};
    assign w_ge    = (w_shift >= r_den);
    assign w_diff  = w_shift - r_den;

    assign o_status.zero_div = (i_divisor == '0);
    assign o_status.last     = (r_cnt == CW'(DATA_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_dbz <= 1'b0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
            r_dbz <= (i_divisor == '0);
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num      <= w_num_mag;
            r_den      <= w_den_mag;
            r_rem      <= '0;
            r_neg      <= i_dividend[DATA_WIDTH-1] ^ i_divisor[DATA_WIDTH-1];
            r_quotient <= '0;
        end else if (i_cmd.step) begin
            // quotient bits shift in where dividend bits shift out
            r_num <= {r_num[DATA_WIDTH-2:0], w_ge};
            r_rem <= w_ge ? w_diff : w_shift;
        end else if (i_cmd.finish) begin
            priority if (r_neg) begin
                r_quotient <= ~r_num + 1'b1;
            end else if (r_num[DATA_WIDTH-1]) begin
                r_quotient <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
            end else begin
                r_quotient <= r_num;
            end
        end
    end

    assign o_quotient       = r_quotient;
    assign o_divide_by_zero = r_dbz;

endmodule

FILE: rtl/core/signed_int_divider.sv
// signed integer divider, quotient truncated toward zero
// input channel: i_in_valid / o_in_ready with i_dividend and i_divisor;
// a transaction is taken at a rising edge with valid and ready both high
// output channel: o_out_valid / i_out_ready with o_quotient and
// o_divide_by_zero, exactly one result transaction per input transaction
// restoring shift-and-subtract, one quotient bit per cycle in one shared
// subtractor: a result is valid once the run and finish states are through,
// or directly from idle for a zero divisor (quotient 0, flag set)
// one item at a time: o_in_ready is high only while idle, so a new item
// is accepted only once the previous result transaction has completed
// most negative value over -1 saturates to the largest positive value
// a stalled receiver holds the result register and blocks new input
// until the result transaction completes
// synchronous active-low reset returns to idle with no result pending
module signed_int_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_dividend,
    input  logic signed [DATA_WIDTH-1:0] i_divisor,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_quotient,
    output logic                         o_divide_by_zero
);

    sid_pkg::t_cmd    w_cmd;
    sid_pkg::t_status w_status;

    sid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    sid_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_status         (w_status),
        .o_quotient       (o_quotient),
        .o_divide_by_zero (o_divide_by_zero)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_by_zero) |-> (o_quotient == '0))
        else $error("divide by zero result is not zero");

    a_nonzero_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_divisor != '0)) |=> !o_out_valid)
        else $error("result valid too early");

    a_zero_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_divisor == '0)) |=>
        (o_out_valid && o_divide_by_zero))
        else $error("zero divisor result missing");

endmodule
